[hw/rtl/tccg_pkg.sv]
// -----------------------------------------------------------------------------
// Text console cursor grid package
// Shared constants, codes and interface types of the text console grid.
// -----------------------------------------------------------------------------
package tccg_pkg;

    localparam int MAX_COLUMNS_DEF     = 256;
    localparam int MAX_ROWS_STORED_DEF = 128;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam int         TAB_STOP   = 8;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    localparam logic [3:0] FG_RESET   = 4'd7;
    localparam logic [3:0] BG_RESET   = 4'd0;
    localparam logic [8:0] COLS_RESET = 9'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_FG   = 2'd0,
        CFG_BG   = 2'd1,
        CFG_COLS = 2'd2,
        CFG_ROWS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] rows;
        logic [8:0] cols;
        logic [7:0] attr;
    } t_geom;

    typedef struct packed {
        logic re;
        logic we_char;
        logic we_attr;
    } t_mem_ctl;

endpackage

[hw/rtl/tccg_store.sv]
// -----------------------------------------------------------------------------
// Text console cell store
// Character and attribute memories sharing one write port and one registered
// read port, with separate write and read addresses.
// -----------------------------------------------------------------------------
module tccg_store #(
    parameter int AW = $clog2(tccg_pkg::MAX_ROWS_STORED_DEF)
                     + $clog2(tccg_pkg::MAX_COLUMNS_DEF)
) (
    input  logic                i_clk,
    input  tccg_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]       i_waddr,
    input  logic [AW-1:0]       i_raddr,
    input  logic [7:0]          i_wchar,
    input  logic [7:0]          i_wattr,
    output logic [7:0]          o_rchar,
    output logic [7:0]          o_rattr
);
    logic [7:0] r_char_mem [2**AW];
    logic [7:0] r_attr_mem [2**AW];
    logic [7:0] r_rchar;
    logic [7:0] r_rattr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_char) begin
            r_char_mem[i_waddr] <= i_wchar;
        end
        if (i_ctl.re) begin
            r_rchar <= r_char_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_attr) begin
            r_attr_mem[i_waddr] <= i_wattr;
        end
        if (i_ctl.re) begin
            r_rattr <= r_attr_mem[i_raddr];
        end
    end

    assign o_rchar = r_rchar;
    assign o_rattr = r_rattr;

endmodule

[hw/rtl/tccg_seq.sv]
// -----------------------------------------------------------------------------
// Text console sequencer
// Cursor registers and the state machine that walks the cell store for puts,
// reads, scrolls, clears and the power-up fill.
// -----------------------------------------------------------------------------
module tccg_seq #(
    parameter int MAX_COLUMNS     = tccg_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS_STORED = tccg_pkg::MAX_ROWS_STORED_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_action,
    input  logic [7:0]          i_char_code,
    input  logic [6:0]          i_read_row,
    input  logic [7:0]          i_read_col,
    input  tccg_pkg::t_geom     i_geom,
    output tccg_pkg::t_mem_ctl  o_mem_ctl,
    output logic [$clog2(MAX_ROWS_STORED)+$clog2(MAX_COLUMNS)-1:0] o_waddr,
    output logic [$clog2(MAX_ROWS_STORED)+$clog2(MAX_COLUMNS)-1:0] o_raddr,
    output logic [7:0]          o_wchar,
    output logic [7:0]          o_wattr,
    input  logic [7:0]          i_rchar,
    input  logic [7:0]          i_rattr,
    output logic                o_result_valid,
    output logic [6:0]          o_cursor_row,
    output logic [8:0]          o_cursor_col,
    output logic                o_scrolled,
    output logic [7:0]          o_cell_char,
    output logic [7:0]          o_cell_attr
);
    import tccg_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS_STORED);
    localparam int AW = RW + CW;

    typedef enum logic [6:0] {
        S_INIT = 7'b000_0001,
        S_IDLE = 7'b000_0010,
        S_PUT  = 7'b000_0100,
        S_SCRL = 7'b000_1000,
        S_SFIL = 7'b001_0000,
        S_CLR  = 7'b010_0000,
        S_RDW  = 7'b100_0000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [6:0] row, input logic [8:0] col);
        cell_addr = {row[RW-1:0], col[CW-1:0]};
    endfunction

    t_state        r_state, n_state;
    logic [6:0]    r_row, n_row;
    logic [8:0]    r_col, n_col;
    logic [7:0]    r_char, n_char;
    logic          r_scr, n_scr;
    logic [6:0]    r_y, n_y;
    logic [8:0]    r_x, n_x;
    logic [AW-1:0] r_ia, n_ia;
    logic          r_cv, n_cv;
    logic [6:0]    r_cy, n_cy;
    logic [8:0]    r_cx, n_cx;
    logic          r_ovalid;
    logic [6:0]    r_orow;
    logic [8:0]    r_ocol;
    logic          r_oscr;
    logic [7:0]    r_ochar;
    logic [7:0]    r_oattr;

    logic          fin;
    logic          go_scroll;
    logic [7:0]    cc;
    logic [7:0]    ca;
    logic [6:0]    rows_m1;
    logic          last_row;
    logic          col_full;
    logic [8:0]    col_p1;
    logic          x_last;
    logic          y_last;
    logic [7:0]    put_code;

    assign rows_m1  = 7'(i_geom.rows - 8'd1);
    assign last_row = (({1'b0, r_row} + 8'd1) >= i_geom.rows);
    assign col_full = (r_col >= i_geom.cols);
    assign col_p1   = r_col + 9'd1;
    assign x_last   = (r_x == (i_geom.cols - 9'd1));
    assign y_last   = ({1'b0, r_y} == (i_geom.rows - 8'd1));
    assign put_code = (r_char == CH_TAB) ? SPACE_CHAR : r_char;

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_char    = r_char;
        n_scr     = r_scr;
        n_y       = r_y;
        n_x       = r_x;
        n_ia      = r_ia;
        n_cv      = 1'b0;
        n_cy      = r_y - 7'd1;
        n_cx      = r_x;
        o_mem_ctl = '0;
        o_waddr   = cell_addr(r_row, r_col);
        o_raddr   = cell_addr(r_y, r_x);
        o_wchar   = put_code;
        o_wattr   = i_geom.attr;
        fin       = 1'b0;
        go_scroll = 1'b0;
        cc        = 8'd0;
        ca        = 8'd0;
        unique case (r_state)
            S_INIT: begin
                o_mem_ctl.we_char = 1'b1;
                o_mem_ctl.we_attr = 1'b1;
                o_waddr           = r_ia;
                o_wchar           = SPACE_CHAR;
                o_wattr           = RESET_ATTR;
                n_ia              = r_ia + AW'(1);
                if (&r_ia) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_char = i_char_code;
                    n_scr  = 1'b0;
                    unique case (t_action'(i_action))
                        ACT_PUT: begin
                            n_row   = ({1'b0, r_row} >= i_geom.rows) ? rows_m1 : r_row;
                            n_col   = (r_col > i_geom.cols) ? i_geom.cols : r_col;
                            n_state = S_PUT;
                        end
                        ACT_READ: begin
                            if (({1'b0, i_read_row} < i_geom.rows) &&
                                ({1'b0, i_read_col} < i_geom.cols)) begin
                                o_mem_ctl.re = 1'b1;
                                o_raddr      = cell_addr(i_read_row, {1'b0, i_read_col});
                                n_state      = S_RDW;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            n_y     = 7'd0;
                            n_x     = 9'd0;
                            n_state = S_CLR;
                        end
                        ACT_NOP: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_PUT: begin
                unique case (r_char)
                    CH_LF: begin
                        n_col = 9'd0;
                        if (!last_row) begin
                            n_row = r_row + 7'd1;
                            fin   = 1'b1;
                        end else begin
                            go_scroll = 1'b1;
                        end
                    end
                    CH_CR: begin
                        n_col = 9'd0;
                        fin   = 1'b1;
                    end
                    CH_BS: begin
                        if (r_col != 9'd0) begin
                            n_col             = r_col - 9'd1;
                            o_mem_ctl.we_char = 1'b1;
                            o_waddr           = cell_addr(r_row, r_col - 9'd1);
                            o_wchar           = SPACE_CHAR;
                        end
                        fin = 1'b1;
                    end
                    default: begin
                        if (col_full) begin
                            n_col = 9'd0;
                            if (!last_row) begin
                                n_row = r_row + 7'd1;
                            end else begin
                                go_scroll = 1'b1;
                            end
                        end else begin
                            o_mem_ctl.we_char = 1'b1;
                            o_mem_ctl.we_attr = 1'b1;
                            n_col             = col_p1;
                            if ((r_char != CH_TAB) ||
                                ((col_p1 & 9'(TAB_STOP - 1)) == 9'd0) ||
                                (col_p1 >= i_geom.cols)) begin
                                fin = 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_SCRL: begin
                o_mem_ctl.re = 1'b1;
                n_cv         = 1'b1;
                if (x_last) begin
                    n_x = 9'd0;
                    if (y_last) begin
                        n_state = S_SFIL;
                    end else begin
                        n_y = r_y + 7'd1;
                    end
                end else begin
                    n_x = r_x + 9'd1;
                end
            end
            S_SFIL: begin
                if (!r_cv) begin
                    o_mem_ctl.we_char = 1'b1;
                    o_mem_ctl.we_attr = 1'b1;
                    o_waddr           = cell_addr(rows_m1, r_x);
                    o_wchar           = SPACE_CHAR;
                    if (x_last) begin
                        if (r_char == CH_LF) begin
                            fin = 1'b1;
                        end else begin
                            n_state = S_PUT;
                        end
                    end else begin
                        n_x = r_x + 9'd1;
                    end
                end
            end
            S_CLR: begin
                o_mem_ctl.we_char = 1'b1;
                o_mem_ctl.we_attr = 1'b1;
                o_waddr           = cell_addr(r_y, r_x);
                o_wchar           = SPACE_CHAR;
                if (x_last) begin
                    n_x = 9'd0;
                    if (y_last) begin
                        n_row = 7'd0;
                        n_col = 9'd0;
                        fin   = 1'b1;
                    end else begin
                        n_y = r_y + 7'd1;
                    end
                end else begin
                    n_x = r_x + 9'd1;
                end
            end
            S_RDW: begin
                cc  = i_rchar;
                ca  = i_rattr;
                fin = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_cv) begin
            o_mem_ctl.we_char = 1'b1;
            o_mem_ctl.we_attr = 1'b1;
            o_waddr           = cell_addr(r_cy, r_cx);
            o_wchar           = i_rchar;
            o_wattr           = i_rattr;
        end
        if (go_scroll) begin
            n_scr   = 1'b1;
            n_x     = 9'd0;
            n_y     = 7'd1;
            n_state = (i_geom.rows == 8'd1) ? S_SFIL : S_SCRL;
        end
        if (fin) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ia     <= '0;
            r_row    <= 7'd0;
            r_col    <= 9'd0;
            r_cv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ia     <= n_ia;
            r_row    <= n_row;
            r_col    <= n_col;
            r_cv     <= n_cv;
            r_ovalid <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_scr  <= n_scr;
        r_y    <= n_y;
        r_x    <= n_x;
        r_cy   <= n_cy;
        r_cx   <= n_cx;
        if (fin) begin
            r_orow  <= n_row;
            r_ocol  <= n_col;
            r_oscr  <= n_scr;
            r_ochar <= cc;
            r_oattr <= ca;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_ovalid;
    assign o_cursor_row   = r_orow;
    assign o_cursor_col   = r_ocol;
    assign o_scrolled     = r_oscr;
    assign o_cell_char    = r_ochar;
    assign o_cell_attr    = r_oattr;

endmodule

[hw/rtl/text_console_cursor_grid.sv]
// -----------------------------------------------------------------------------
// Text console cursor grid
// Character and attribute grid with a cursor, control codes, wrap and scroll.
//
//   Channel   Handshake                     Payload
//   command   i_start, o_busy               i_action, i_char_code, i_read_row,
//                                           i_read_col
//   result    o_result_valid (strobe)       o_cursor_row, o_cursor_col,
//                                           o_scrolled, o_cell_char, o_cell_attr
//   config    i_cfg_valid, o_cfg_ready      i_cfg_index, i_cfg_data
//
// A put that wraps moves the cursor to the next line before the character is
// written, and a tab writes spaces up to the next tab stop or the last column.
// A scroll copies every used row but the first up one row through the store
// read port and blanks the last row; a clear blanks every used cell.
// After reset all 2^(log2 rows + log2 columns) cells of the store, 32768 by
// default, are filled with o_busy high; configuration is taken at all times.
// The result strobe lasts one cycle and cannot be stalled.
// -----------------------------------------------------------------------------
module text_console_cursor_grid #(
    parameter int MAX_COLUMNS     = tccg_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS_STORED = tccg_pkg::MAX_ROWS_STORED_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_char_code,
    input  logic [6:0] i_read_row,
    input  logic [7:0] i_read_col,
    output logic       o_result_valid,
    output logic [6:0] o_cursor_row,
    output logic [8:0] o_cursor_col,
    output logic       o_scrolled,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    import tccg_pkg::*;

    localparam int AW = $clog2(MAX_ROWS_STORED) + $clog2(MAX_COLUMNS);

    logic [3:0]    r_fg;
    logic [3:0]    r_bg;
    logic [8:0]    r_cols;
    logic [7:0]    r_rows;
    t_geom         geom;
    t_mem_ctl      mem_ctl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    wchar;
    logic [7:0]    wattr;
    logic [7:0]    rchar;
    logic [7:0]    rattr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg   <= FG_RESET;
            r_bg   <= BG_RESET;
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FG:   r_fg   <= i_cfg_data[3:0];
                CFG_BG:   r_bg   <= i_cfg_data[3:0];
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data[7:0];
            endcase
        end
    end

    always_comb begin
        geom.attr = {r_bg, r_fg};
        if (r_cols == 9'd0) begin
            geom.cols = 9'd1;
        end else if (r_cols > 9'(MAX_COLUMNS)) begin
            geom.cols = 9'(MAX_COLUMNS);
        end else begin
            geom.cols = r_cols;
        end
        if (r_rows == 8'd0) begin
            geom.rows = 8'd1;
        end else if (r_rows > 8'(MAX_ROWS_STORED)) begin
            geom.rows = 8'(MAX_ROWS_STORED);
        end else begin
            geom.rows = r_rows;
        end
    end

    assign o_cfg_ready = 1'b1;

    tccg_seq #(
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_ROWS_STORED (MAX_ROWS_STORED)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_action       (i_action),
        .i_char_code    (i_char_code),
        .i_read_row     (i_read_row),
        .i_read_col     (i_read_col),
        .i_geom         (geom),
        .o_mem_ctl      (mem_ctl),
        .o_waddr        (waddr),
        .o_raddr        (raddr),
        .o_wchar        (wchar),
        .o_wattr        (wattr),
        .i_rchar        (rchar),
        .i_rattr        (rattr),
        .o_result_valid (o_result_valid),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_col   (o_cursor_col),
        .o_scrolled     (o_scrolled),
        .o_cell_char    (o_cell_char),
        .o_cell_attr    (o_cell_attr)
    );

    tccg_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_raddr (raddr),
        .i_wchar (wchar),
        .i_wattr (wattr),
        .o_rchar (rchar),
        .o_rattr (rattr)
    );

endmodule

[hw/rtl/tccg_check.sv]
// -----------------------------------------------------------------------------
// Text console grid port checker
// Tracks command and result transfers at the ports and checks their pairing.
// -----------------------------------------------------------------------------
module tccg_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_result_valid,
    input logic       o_scrolled,
    input logic [7:0] o_cell_char,
    input logic [7:0] o_cell_attr
);
    logic r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_start && !o_busy) begin
            r_pend <= 1'b1;
        end else if (o_result_valid) begin
            r_pend <= 1'b0;
        end
    end

    a_accept_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_result_valid))
        else $error("accepted command neither started work nor produced a result");

    a_result_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> r_pend)
        else $error("result without an outstanding command");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !o_result_valid) |-> !r_pend)
        else $error("block idle while a command is still outstanding");

    a_scroll_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_scrolled) |-> (o_cell_char == 8'd0 && o_cell_attr == 8'd0))
        else $error("scrolling result carries cell data");

endmodule

bind text_console_cursor_grid tccg_check u_tccg_check (.*);

[sim/text_console_cursor_grid_checker.sv]
// -----------------------------------------------------------------------------
// Text console cursor grid checker
// Watches the command, configuration and result channels of the console grid.
// A private copy of the cursor, colors, geometry and character and attribute
// stores predicts the cursor and cell report of every accepted command, and
// each result strobe is compared field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module text_console_cursor_grid_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_char_code,
    input  logic [6:0] i_read_row,
    input  logic [7:0] i_read_col,
    input  logic       i_result_valid,
    input  logic [6:0] i_cursor_row,
    input  logic [8:0] i_cursor_col,
    input  logic       i_scrolled,
    input  logic [7:0] i_cell_char,
    input  logic [7:0] i_cell_attr,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output int         o_pending,
    output int         o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import tccg_pkg::*;

    localparam int GRID_CELLS = MAX_COLUMNS_DEF * MAX_ROWS_STORED_DEF;

    typedef struct packed {
        logic [6:0] row;
        logic [8:0] col;
        logic       scrolled;
        logic [7:0] chr;
        logic [7:0] attr;
    } t_console_report;

    logic [7:0]      grid_chars [GRID_CELLS];
    logic [7:0]      grid_attrs [GRID_CELLS];
    logic [3:0]      fg_sel;
    logic [3:0]      bg_sel;
    logic [8:0]      cols_reg;
    logic [7:0]      rows_reg;
    int              cur_row;
    int              cur_col;
    logic            scroll_seen;
    t_console_report report_queue [$];
    int              mismatch_cnt = 0;

    assign o_failures = mismatch_cnt;

    task automatic report_mismatch(string msg);
        $display("[%0t] %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    function automatic int used_cols();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
        return int'(cols_reg);
    endfunction

    function automatic int used_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS_STORED_DEF) return MAX_ROWS_STORED_DEF;
        return int'(rows_reg);
    endfunction

    function automatic logic [7:0] pen_attr();
        return {bg_sel, fg_sel};
    endfunction

    function automatic int cell_at(int r, int c);
        return (r % MAX_ROWS_STORED_DEF) * MAX_COLUMNS_DEF + (c % MAX_COLUMNS_DEF);
    endfunction

    function automatic void reset_model();
        for (int k = 0; k < GRID_CELLS; k++) begin
            grid_chars[k] = SPACE_CHAR;
            grid_attrs[k] = RESET_ATTR;
        end
        fg_sel   = FG_RESET;
        bg_sel   = BG_RESET;
        cols_reg = COLS_RESET;
        rows_reg = ROWS_RESET;
        cur_row  = 0;
        cur_col  = 0;
    endfunction

    function automatic void blank_row(int y);
        for (int x = 0; x < used_cols(); x++) begin
            grid_chars[cell_at(y, x)] = SPACE_CHAR;
            grid_attrs[cell_at(y, x)] = pen_attr();
        end
    endfunction

    function automatic void scroll_grid();
        int rows;
        int cols;
        rows = used_rows();
        cols = used_cols();
        for (int y = 1; y < rows; y++) begin
            for (int x = 0; x < cols; x++) begin
                grid_chars[cell_at(y - 1, x)] = grid_chars[cell_at(y, x)];
                grid_attrs[cell_at(y - 1, x)] = grid_attrs[cell_at(y, x)];
            end
        end
        blank_row(rows - 1);
        scroll_seen = 1'b1;
    endfunction

    function automatic void line_feed();
        cur_col = 0;
        if (cur_row + 1 < used_rows()) begin
            cur_row++;
        end else begin
            scroll_grid();
        end
    endfunction

    function automatic void store_glyph(logic [7:0] ch);
        if (cur_col >= used_cols()) line_feed();
        grid_chars[cell_at(cur_row, cur_col)] = ch;
        grid_attrs[cell_at(cur_row, cur_col)] = pen_attr();
        cur_col++;
    endfunction

    function automatic void put_char(logic [7:0] ch);
        int rows;
        int cols;
        rows = used_rows();
        cols = used_cols();
        if (cur_row >= rows) cur_row = rows - 1;
        if (cur_col > cols) cur_col = cols;
        case (ch)
            CH_LF: line_feed();
            CH_CR: cur_col = 0;
            CH_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                    grid_chars[cell_at(cur_row, cur_col)] = SPACE_CHAR;
                end
            end
            CH_TAB: begin
                do begin
                    store_glyph(SPACE_CHAR);
                end while ((cur_col % TAB_STOP) != 0 && cur_col < cols);
            end
            default: store_glyph(ch);
        endcase
    endfunction

    function automatic void write_setting(t_cfg_idx idx, logic [8:0] data);
        case (idx)
            CFG_FG:   fg_sel   = data[3:0];
            CFG_BG:   bg_sel   = data[3:0];
            CFG_COLS: cols_reg = data;
            CFG_ROWS: rows_reg = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic t_console_report console_step(t_action act, logic [7:0] ch,
                                                     logic [6:0] rr, logic [7:0] rc);
        t_console_report rep;
        rep = '0;
        scroll_seen = 1'b0;
        case (act)
            ACT_PUT: put_char(ch);
            ACT_READ: begin
                if (int'(rr) < used_rows() && int'(rc) < used_cols()) begin
                    rep.chr  = grid_chars[cell_at(rr, rc)];
                    rep.attr = grid_attrs[cell_at(rr, rc)];
                end
            end
            ACT_CLEAR: begin
                for (int y = 0; y < used_rows(); y++) blank_row(y);
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
        rep.row      = cur_row[6:0];
        rep.col      = cur_col[8:0];
        rep.scrolled = scroll_seen;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_console_report want;
        string           bad;
        if (!i_rst_n) begin
            reset_model();
            report_queue.delete();
        end else begin
            if (i_result_valid) begin
                if (report_queue.size() == 0) begin
                    report_mismatch("result strobe with no command outstanding");
                end else begin
                    want = report_queue.pop_front();
                    bad  = "";
                    if (i_cursor_row !== want.row)      bad = {bad, " cursor_row"};
                    if (i_cursor_col !== want.col)      bad = {bad, " cursor_col"};
                    if (i_scrolled   !== want.scrolled) bad = {bad, " scrolled"};
                    if (i_cell_char  !== want.chr)      bad = {bad, " cell_char"};
                    if (i_cell_attr  !== want.attr)     bad = {bad, " cell_attr"};
                    if (bad != "") begin
                        report_mismatch($sformatf(
                            "bad%s: got %0d,%0d s%0b %h/%h, expected %0d,%0d s%0b %h/%h",
                            bad, i_cursor_row, i_cursor_col, i_scrolled, i_cell_char,
                            i_cell_attr, want.row, want.col, want.scrolled, want.chr,
                            want.attr));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_setting(t_cfg_idx'(i_cfg_index), i_cfg_data);
            end
            if (i_start && !i_busy) begin
                report_queue.push_back(console_step(t_action'(i_action), i_char_code,
                                                    i_read_row, i_read_col));
            end
        end
        o_pending <= report_queue.size();
    end

endmodule

[sim/text_console_cursor_grid_tb.sv]
// -----------------------------------------------------------------------------
// Text console cursor grid testbench
// Drives commands and register writes into the console grid: a directed pass
// over reads, control codes, wrap and scroll at the smallest and the default
// geometry, a long scroll at the largest geometry, then random phases with
// random geometry, colors and command mix. The checker predicts and compares.
// -----------------------------------------------------------------------------
module text_console_cursor_grid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccg_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 480;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       start       = 1'b0;
    logic [1:0] cmd_action  = ACT_NOP;
    logic [7:0] cmd_char    = 8'h00;
    logic [6:0] cmd_row     = 7'd0;
    logic [7:0] cmd_col     = 8'd0;
    logic       cfg_valid   = 1'b0;
    logic [1:0] cfg_index   = CFG_FG;
    logic [8:0] cfg_data    = 9'd0;
    logic       busy;
    logic       result_valid;
    logic [6:0] cursor_row;
    logic [8:0] cursor_col;
    logic       scrolled;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       cfg_ready;
    int         pending;
    int         fail_count;
    bit         idle_en     = 1'b1;
    int         cycle_cnt   = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    text_console_cursor_grid u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_action       (cmd_action),
        .i_char_code    (cmd_char),
        .i_read_row     (cmd_row),
        .i_read_col     (cmd_col),
        .o_result_valid (result_valid),
        .o_cursor_row   (cursor_row),
        .o_cursor_col   (cursor_col),
        .o_scrolled     (scrolled),
        .o_cell_char    (cell_char),
        .o_cell_attr    (cell_attr),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    text_console_cursor_grid_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (cmd_action),
        .i_char_code    (cmd_char),
        .i_read_row     (cmd_row),
        .i_read_col     (cmd_col),
        .i_result_valid (result_valid),
        .i_cursor_row   (cursor_row),
        .i_cursor_col   (cursor_col),
        .i_scrolled     (scrolled),
        .i_cell_char    (cell_char),
        .i_cell_attr    (cell_attr),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_failures     (fail_count)
    );

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_cmd(t_action act, logic [7:0] ch, logic [6:0] rr, logic [7:0] rc);
        while (idle_en && $urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        cmd_action <= act;
        cmd_char   <= ch;
        cmd_row    <= rr;
        cmd_col    <= rc;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
    endtask

    task automatic put(logic [7:0] ch);
        send_cmd(ACT_PUT, ch, 7'($urandom), 8'($urandom));
    endtask

    task automatic read_cell(logic [6:0] rr, logic [7:0] rc);
        send_cmd(ACT_READ, 8'($urandom), rr, rc);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [8:0] val);
        while (idle_en && $urandom_range(99) < 36) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Holds off the sender until every transfer has returned its result.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy !== 1'b0) @(posedge clk);
    endtask

    task automatic random_item(int cols, int rows, bit tab_mode);
        int         pick;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 60) begin
            case ($urandom_range(9))
                0:       ch = CH_LF;
                1:       ch = CH_CR;
                2, 3:    ch = CH_BS;
                4:       ch = CH_TAB;
                default: ch = 8'($urandom);
            endcase
            if (tab_mode && $urandom_range(3) != 0) ch = CH_TAB;
            put(ch);
        end else if (pick < 88) begin
            if ($urandom_range(4) == 0) begin
                read_cell(7'($urandom), 8'($urandom));
            end else begin
                read_cell(7'($urandom_range(rows - 1)), 8'($urandom_range(cols - 1)));
            end
        end else if (pick < 94) begin
            send_cmd(ACT_CLEAR, 8'($urandom), 7'($urandom), 8'($urandom));
        end else begin
            send_cmd(ACT_NOP, 8'($urandom), 7'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int kind;
        int prev_kind;
        int n;
        int random_cnt;
        int cv;
        int rv;
        int geo_cols;
        int geo_rows;
        int eff_c;
        int eff_r;
        bit tab_mode;
        random_cnt = 0;
        prev_kind  = 9;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        read_cell(7'd0, 8'd0);
        read_cell(7'd24, 8'd79);
        read_cell(7'd25, 8'd0);
        read_cell(7'd0, 8'd80);
        read_cell(7'd127, 8'd255);
        put(8'h48);
        put(8'hFF);
        put(8'h00);
        put(CH_BS);
        read_cell(7'd0, 8'd2);
        put(CH_CR);
        put(CH_BS);
        put(CH_TAB);
        send_cmd(ACT_NOP, 8'hA5, 7'h55, 8'h5A);
        send_cmd(ACT_CLEAR, 8'h00, 7'd0, 8'd0);
        put(CH_LF);
        put(CH_TAB);
        settle();

        write_reg(CFG_FG, 9'h1FF);
        write_reg(CFG_BG, 9'h10A);
        write_reg(CFG_COLS, 9'd0);
        write_reg(CFG_ROWS, 9'd0);
        read_cell(7'd1, 8'd0);
        put(8'h61);
        put(CH_TAB);
        read_cell(7'd0, 8'd0);
        put(CH_LF);
        put(CH_BS);
        send_cmd(ACT_CLEAR, 8'hFF, 7'h7F, 8'hFF);
        settle();

        idle_en = 1'b0;
        write_reg(CFG_FG, 9'h0F0);
        write_reg(CFG_BG, 9'h00F);
        write_reg(CFG_COLS, 9'h1FF);
        write_reg(CFG_ROWS, 9'd128);
        read_cell(7'd127, 8'd255);
        send_cmd(ACT_CLEAR, 8'h00, 7'd0, 8'd0);
        for (int i = 0; i < 140; i++) begin
            put((i % 16 == 15) ? 8'($urandom) : CH_LF);
        end
        read_cell(7'd127, 8'd0);
        read_cell(7'd126, 8'd255);
        settle();
        geo_cols = 511;
        geo_rows = 128;

        while (random_cnt < RANDOM_ITEMS) begin
            kind     = $urandom_range(9);
            tab_mode = 1'b0;
            if (kind < 6) begin
                cv = $urandom_range(1, 24);
                rv = $urandom_range(1, 6);
            end else if (kind == 6) begin
                cv = $urandom_range(1) ? 0 : $urandom_range(257, 511);
                rv = $urandom_range(0, 2);
            end else if (kind == 7) begin
                rv = $urandom_range(1) ? 0 : $urandom_range(129, 255);
                cv = $urandom_range(0, 2);
            end else if (kind == 8) begin
                cv       = $urandom_range(200, 256);
                rv       = $urandom_range(1, 2);
                tab_mode = 1'b1;
            end else begin
                cv = $urandom_range(25, 80);
                rv = $urandom_range(6, 25);
            end
            idle_en = ($urandom_range(7) != 0);
            if ($urandom_range(3) != 0) write_reg(CFG_FG, 9'($urandom));
            if ($urandom_range(3) != 0) write_reg(CFG_BG, 9'($urandom));
            if (!(kind < 6 && prev_kind < 6 && $urandom_range(3) == 0)) begin
                write_reg(CFG_COLS, 9'(cv));
                write_reg(CFG_ROWS, 9'(rv));
                geo_cols = cv;
                geo_rows = rv;
            end
            prev_kind = kind;
            eff_c = (geo_cols == 0) ? 1 :
                    (geo_cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : geo_cols;
            eff_r = (geo_rows == 0) ? 1 :
                    (geo_rows > MAX_ROWS_STORED_DEF) ? MAX_ROWS_STORED_DEF : geo_rows;
            n = $urandom_range(20, 60);
            repeat (n) random_item(eff_c, eff_r, tab_mode);
            random_cnt += n;
            settle();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
